>>> src/rmq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the rotation matrix to quaternion block
// no dependencies; used by the cell modules and the top level

package rmq_pkg;

   localparam int FIELD_W = 18;

   // square-root cell widths: 38-bit radicand, one root bit per cell
   localparam int SQ_ARG_W  = 38;
   localparam int SQ_ROOT_W = 19;
   localparam int SQ_REM_W  = 20;
   localparam int SQ_STEPS  = 19;

   // divider cell widths: one quotient bit per cell
   localparam int DV_DEN_W = 20;
   localparam int DV_REM_W = 20;
   localparam int DV_QUO_W = 17;
   localparam int DV_STEPS = 17;

   localparam int MAG_W  = 18;
   localparam int PROD_W = 35;
   localparam int NUM_W  = 36;

   localparam logic [1:0] STATUS_NORMAL    = 2'd0;
   localparam logic [1:0] STATUS_IDENTITY  = 2'd1;
   localparam logic [1:0] STATUS_ZERO_AXIS = 2'd2;

   localparam logic signed [FIELD_W-1:0] ONE_Q16 = 18'sd65536;

   // item data riding beside the square-root chain
   typedef struct packed {
      logic [1:0]       status;
      logic [2:0]       sign;
      logic [MAG_W-1:0] mag_x;
      logic [MAG_W-1:0] mag_y;
      logic [MAG_W-1:0] mag_z;
   } sq_side_type;

   // item data riding beside the divider chain
   typedef struct packed {
      logic [1:0]          status;
      logic [2:0]          sign;
      logic [DV_QUO_W-1:0] w;
   } dv_side_type;

endpackage

>>> src/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// top level: rotation matrix to unit quaternion, axis-angle route
// depends on rmq_pkg, rmq_sqrt_cell and rmq_div_cell

// Takes one Q2.16 rotation matrix per cycle while req_stall is low and
// returns one Q2.16 quaternion with a status code via the input register,
// squaring stage, 19 square-root cells, product stage, 17 divider cells and
// output register: three lanes of 19 square-root cells for w, sin(theta/2)
// and the difference-vector norm, then three lanes of 17 divider cells for
// the normalised vector parts. All stages advance together; while a result
// waits at the output under stall, the whole pipe holds and req_stall is
// raised. The user must write the identity threshold through csr_wr_en only
// while the block is idle; the block itself does not enforce this.

module rotation_matrix_to_quaternion (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_wr_en,
   input  logic [15:0]                              csr_wr_data,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [rmq_pkg::FIELD_W-1:0]       req_r00,
   input  logic signed [rmq_pkg::FIELD_W-1:0]       req_r01,
   input  logic signed [rmq_pkg::FIELD_W-1:0]       req_r02,
   input  logic signed [rmq_pkg::FIELD_W-1:0]       req_r10,
   input  logic signed [rmq_pkg::FIELD_W-1:0]       req_r11,
   input  logic signed [rmq_pkg::FIELD_W-1:0]       req_r12,
   input  logic signed [rmq_pkg::FIELD_W-1:0]       req_r20,
   input  logic signed [rmq_pkg::FIELD_W-1:0]       req_r21,
   input  logic signed [rmq_pkg::FIELD_W-1:0]       req_r22,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [rmq_pkg::FIELD_W-1:0]       rsp_quat_w,
   output logic signed [rmq_pkg::FIELD_W-1:0]       rsp_quat_x,
   output logic signed [rmq_pkg::FIELD_W-1:0]       rsp_quat_y,
   output logic signed [rmq_pkg::FIELD_W-1:0]       rsp_quat_z,
   output logic [1:0]                               rsp_status
);

   localparam int SQ_N = rmq_pkg::SQ_STEPS;
   localparam int DV_N = rmq_pkg::DV_STEPS;

   logic en;
   logic [15:0] thr_ff;

   // input stage
   logic signed [19:0] trace;
   logic signed [18:0] c_raw, c_cl;
   logic [17:0]        omc, wb;
   logic signed [18:0] dx, dy, dz;
   logic [rmq_pkg::MAG_W-1:0] mx, my, mz;
   logic [1:0]         st0;

   logic               s1_valid_ff;
   logic [17:0]        s1_omc_ff, s1_wb_ff;
   rmq_pkg::sq_side_type s1_side_ff, s1_side_in;

   // squaring stage
   logic               s2_valid_ff;
   logic [17:0]        s2_omc_ff, s2_wb_ff;
   logic [35:0]        s2_sqx_ff, s2_sqy_ff, s2_sqz_ff;
   rmq_pkg::sq_side_type s2_side_ff;

   // square-root chain
   logic [rmq_pkg::SQ_ARG_W-1:0]  sq_arg  [3][SQ_N+1];
   logic [rmq_pkg::SQ_REM_W-1:0]  sq_rem  [3][SQ_N+1];
   logic [rmq_pkg::SQ_ROOT_W-1:0] sq_root [3][SQ_N+1];
   logic                          sq_valid_ff [SQ_N];
   rmq_pkg::sq_side_type          sq_side_ff  [SQ_N];

   // product stage
   logic                          pm_valid_ff;
   logic [rmq_pkg::PROD_W-1:0]    pm_prod_ff [3];
   logic [rmq_pkg::SQ_ROOT_W-1:0] pm_n_ff;
   rmq_pkg::dv_side_type          pm_side_ff;
   logic [rmq_pkg::MAG_W-1:0]     pm_mag [3];
   logic [rmq_pkg::NUM_W-1:0]     pm_num [3];

   // divider chain
   logic [rmq_pkg::DV_DEN_W-1:0] dv_den [3][DV_N+1];
   logic [rmq_pkg::DV_REM_W-1:0] dv_rem [3][DV_N+1];
   logic [rmq_pkg::DV_QUO_W-1:0] dv_num [3][DV_N+1];
   logic [rmq_pkg::DV_QUO_W-1:0] dv_quo [3][DV_N+1];
   logic                         dv_valid_ff [DV_N];
   rmq_pkg::dv_side_type         dv_side_ff  [DV_N];

   // output register
   logic                              rsp_valid_ff;
   logic signed [rmq_pkg::FIELD_W-1:0] part_in [3];
   logic signed [rmq_pkg::FIELD_W-1:0] w_in, x_ff, y_ff, z_ff, w_ff;
   logic [1:0]                        status_ff;

   // whole pipe holds while a result sits at the output under stall
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // cosine, clamp, difference vector and special-case decision
   always_comb begin
      trace = 20'(req_r00) + 20'(req_r11) + 20'(req_r22) - 20'sd65536;
      c_raw = trace[19:1];
      if (c_raw > 19'sd65536) begin
         c_cl = 19'sd65536;
      end else if (c_raw < -19'sd65536) begin
         c_cl = -19'sd65536;
      end else begin
         c_cl = c_raw;
      end
      omc = 18'(19'sd65536 - c_cl);
      wb  = 18'(19'sd65536 + c_cl);
      dx  = 19'(req_r21) - 19'(req_r12);
      dy  = 19'(req_r02) - 19'(req_r20);
      dz  = 19'(req_r10) - 19'(req_r01);
      mx  = dx[18] ? 18'(-dx) : dx[17:0];
      my  = dy[18] ? 18'(-dy) : dy[17:0];
      mz  = dz[18] ? 18'(-dz) : dz[17:0];
      if (omc <= {2'b00, thr_ff}) begin
         st0 = rmq_pkg::STATUS_IDENTITY;
      end else if (dx == '0 && dy == '0 && dz == '0) begin
         st0 = rmq_pkg::STATUS_ZERO_AXIS;
      end else begin
         st0 = rmq_pkg::STATUS_NORMAL;
      end
      s1_side_in.status = st0;
      s1_side_in.sign   = {dz[18], dy[18], dx[18]};
      s1_side_in.mag_x  = mx;
      s1_side_in.mag_y  = my;
      s1_side_in.mag_z  = mz;
   end

   // input and squaring stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s1_omc_ff  <= omc;
         s1_wb_ff   <= wb;
         s1_side_ff <= s1_side_in;
         s2_omc_ff  <= s1_omc_ff;
         s2_wb_ff   <= s1_wb_ff;
         s2_side_ff <= s1_side_ff;
         s2_sqx_ff  <= s1_side_ff.mag_x * s1_side_ff.mag_x;
         s2_sqy_ff  <= s1_side_ff.mag_y * s1_side_ff.mag_y;
         s2_sqz_ff  <= s1_side_ff.mag_z * s1_side_ff.mag_z;
      end
   end

   // radicands: (1+c)/2 and (1-c)/2 scaled by 2^32, and the squared norm
   assign sq_arg[0][0] = {5'b0, s2_wb_ff, 15'b0};
   assign sq_arg[1][0] = {5'b0, s2_omc_ff, 15'b0};
   assign sq_arg[2][0] = 38'(s2_sqx_ff) + 38'(s2_sqy_ff) + 38'(s2_sqz_ff);

   // square-root chain, three lanes
   for (genvar l = 0; l < 3; l++) begin : g_sq_lane
      assign sq_rem[l][0]  = '0;
      assign sq_root[l][0] = '0;
      for (genvar k = 0; k < SQ_N; k++) begin : g_sq_cell
         rmq_sqrt_cell u_cell (
            .clock  (clock),
            .en     (en),
            .arg_i  (sq_arg[l][k]),
            .rem_i  (sq_rem[l][k]),
            .root_i (sq_root[l][k]),
            .arg_o  (sq_arg[l][k+1]),
            .rem_o  (sq_rem[l][k+1]),
            .root_o (sq_root[l][k+1])
         );
      end
   end

   // item data beside the square-root chain
   for (genvar k = 0; k < SQ_N; k++) begin : g_sq_side
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (en) begin
            sq_valid_ff[k] <= (k == 0) ? s2_valid_ff : sq_valid_ff[(k == 0) ? 0 : k-1];
         end
         if (en) begin
            sq_side_ff[k] <= (k == 0) ? s2_side_ff : sq_side_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign pm_mag[0] = sq_side_ff[SQ_N-1].mag_x;
   assign pm_mag[1] = sq_side_ff[SQ_N-1].mag_y;
   assign pm_mag[2] = sq_side_ff[SQ_N-1].mag_z;

   // product stage: sin(theta/2) times each difference magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         pm_valid_ff <= 1'b0;
      end else if (en) begin
         pm_valid_ff <= sq_valid_ff[SQ_N-1];
      end
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            pm_prod_ff[l] <= sq_root[1][SQ_N][rmq_pkg::DV_QUO_W-1:0] * pm_mag[l];
         end
         pm_n_ff           <= sq_root[2][SQ_N];
         pm_side_ff.status <= sq_side_ff[SQ_N-1].status;
         pm_side_ff.sign   <= sq_side_ff[SQ_N-1].sign;
         pm_side_ff.w      <= sq_root[0][SQ_N][rmq_pkg::DV_QUO_W-1:0];
      end
   end

   // divider chain: (2 s |d| + n) / (2 n), three lanes
   for (genvar l = 0; l < 3; l++) begin : g_dv_lane
      assign pm_num[l]    = {pm_prod_ff[l], 1'b0} + 36'(pm_n_ff);
      assign dv_den[l][0] = {pm_n_ff, 1'b0};
      assign dv_rem[l][0] = {1'b0, pm_num[l][rmq_pkg::NUM_W-1:rmq_pkg::DV_QUO_W]};
      assign dv_num[l][0] = pm_num[l][rmq_pkg::DV_QUO_W-1:0];
      assign dv_quo[l][0] = '0;
      for (genvar k = 0; k < DV_N; k++) begin : g_dv_cell
         rmq_div_cell u_cell (
            .clock (clock),
            .en    (en),
            .den_i (dv_den[l][k]),
            .rem_i (dv_rem[l][k]),
            .num_i (dv_num[l][k]),
            .quo_i (dv_quo[l][k]),
            .den_o (dv_den[l][k+1]),
            .rem_o (dv_rem[l][k+1]),
            .num_o (dv_num[l][k+1]),
            .quo_o (dv_quo[l][k+1])
         );
      end
   end

   // item data beside the divider chain
   for (genvar k = 0; k < DV_N; k++) begin : g_dv_side
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[k] <= (k == 0) ? pm_valid_ff : dv_valid_ff[(k == 0) ? 0 : k-1];
         end
         if (en) begin
            dv_side_ff[k] <= (k == 0) ? pm_side_ff : dv_side_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // apply signs and special cases
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (dv_side_ff[DV_N-1].sign[l]) begin
            part_in[l] = -$signed({1'b0, dv_quo[l][DV_N]});
         end else begin
            part_in[l] = $signed({1'b0, dv_quo[l][DV_N]});
         end
      end
      w_in = $signed({1'b0, dv_side_ff[DV_N-1].w});
      case (dv_side_ff[DV_N-1].status)
         rmq_pkg::STATUS_IDENTITY: begin
            w_in = rmq_pkg::ONE_Q16;
            for (int l = 0; l < 3; l++) part_in[l] = '0;
         end
         rmq_pkg::STATUS_ZERO_AXIS: begin
            w_in = '0;
            for (int l = 0; l < 3; l++) part_in[l] = '0;
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid_ff[DV_N-1];
      end
      if (en) begin
         w_ff      <= w_in;
         x_ff      <= part_in[0];
         y_ff      <= part_in[1];
         z_ff      <= part_in[2];
         status_ff <= dv_side_ff[DV_N-1].status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_w = w_ff;
   assign rsp_quat_x = x_ff;
   assign rsp_quat_y = y_ff;
   assign rsp_quat_z = z_ff;
   assign rsp_status = status_ff;

   // identity items carry the unit quaternion
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == rmq_pkg::STATUS_IDENTITY) |->
      (rsp_quat_w == rmq_pkg::ONE_Q16 && rsp_quat_x == '0 && rsp_quat_y == '0
       && rsp_quat_z == '0))
      else $error("identity item not unit quaternion");

   // zero-axis items are all zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == rmq_pkg::STATUS_ZERO_AXIS) |->
      (rsp_quat_w == '0 && rsp_quat_x == '0 && rsp_quat_y == '0 && rsp_quat_z == '0))
      else $error("zero-axis item not cleared");

   // normal items keep w and x within the unit range
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == rmq_pkg::STATUS_NORMAL) |->
      (rsp_quat_w >= 0 && rsp_quat_w <= rmq_pkg::ONE_Q16
       && rsp_quat_x <= rmq_pkg::ONE_Q16 && rsp_quat_x >= -rmq_pkg::ONE_Q16))
      else $error("quaternion part out of range");

   // a held result keeps the product-stage registers frozen
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(pm_n_ff) && $stable(pm_valid_ff)))
      else $error("pipe moved under output stall");

endmodule

>>> src/rmq_sqrt_cell.sv
`timescale 1ns / 1ps
// one cell of the square-root chain: settles one root bit per cycle while en is high
// depends on rmq_pkg for widths

module rmq_sqrt_cell (
   input  logic                           clock,
   input  logic                           en,
   input  logic [rmq_pkg::SQ_ARG_W-1:0]   arg_i,
   input  logic [rmq_pkg::SQ_REM_W-1:0]   rem_i,
   input  logic [rmq_pkg::SQ_ROOT_W-1:0]  root_i,
   output logic [rmq_pkg::SQ_ARG_W-1:0]   arg_o,
   output logic [rmq_pkg::SQ_REM_W-1:0]   rem_o,
   output logic [rmq_pkg::SQ_ROOT_W-1:0]  root_o
);

   logic [rmq_pkg::SQ_REM_W+1:0]  cur;
   logic [rmq_pkg::SQ_REM_W+1:0]  trial;
   logic [rmq_pkg::SQ_REM_W+1:0]  diff;
   logic                          take;
   logic [rmq_pkg::SQ_ARG_W-1:0]  arg_in, arg_ff;
   logic [rmq_pkg::SQ_REM_W-1:0]  rem_in, rem_ff;
   logic [rmq_pkg::SQ_ROOT_W-1:0] root_in, root_ff;

   // bring down the next bit pair and try the next root bit
   always_comb begin
      cur     = {rem_i, arg_i[rmq_pkg::SQ_ARG_W-1 -: 2]};
      trial   = {1'b0, root_i, 2'b01};
      take    = (cur >= trial);
      diff    = cur - trial;
      arg_in  = {arg_i[rmq_pkg::SQ_ARG_W-3:0], 2'b00};
      rem_in  = take ? diff[rmq_pkg::SQ_REM_W-1:0] : cur[rmq_pkg::SQ_REM_W-1:0];
      root_in = {root_i[rmq_pkg::SQ_ROOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         arg_ff  <= arg_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign arg_o  = arg_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

>>> src/rmq_div_cell.sv
`timescale 1ns / 1ps
// one cell of the restoring divider chain: settles one quotient bit per cycle while en is high
// depends on rmq_pkg for widths

module rmq_div_cell (
   input  logic                          clock,
   input  logic                          en,
   input  logic [rmq_pkg::DV_DEN_W-1:0]  den_i,
   input  logic [rmq_pkg::DV_REM_W-1:0]  rem_i,
   input  logic [rmq_pkg::DV_QUO_W-1:0]  num_i,
   input  logic [rmq_pkg::DV_QUO_W-1:0]  quo_i,
   output logic [rmq_pkg::DV_DEN_W-1:0]  den_o,
   output logic [rmq_pkg::DV_REM_W-1:0]  rem_o,
   output logic [rmq_pkg::DV_QUO_W-1:0]  num_o,
   output logic [rmq_pkg::DV_QUO_W-1:0]  quo_o
);

   logic [rmq_pkg::DV_REM_W:0]   cur;
   logic [rmq_pkg::DV_REM_W:0]   diff;
   logic                         take;
   logic [rmq_pkg::DV_DEN_W-1:0] den_ff;
   logic [rmq_pkg::DV_REM_W-1:0] rem_in, rem_ff;
   logic [rmq_pkg::DV_QUO_W-1:0] num_in, num_ff;
   logic [rmq_pkg::DV_QUO_W-1:0] quo_in, quo_ff;

   // shift in the next numerator bit and subtract where it goes
   always_comb begin
      cur    = {rem_i, num_i[rmq_pkg::DV_QUO_W-1]};
      take   = (cur >= {1'b0, den_i});
      diff   = cur - {1'b0, den_i};
      rem_in = take ? diff[rmq_pkg::DV_REM_W-1:0] : cur[rmq_pkg::DV_REM_W-1:0];
      num_in = {num_i[rmq_pkg::DV_QUO_W-2:0], 1'b0};
      quo_in = {quo_i[rmq_pkg::DV_QUO_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff <= den_i;
         rem_ff <= rem_in;
         num_ff <= num_in;
         quo_ff <= quo_in;
      end
   end

   assign den_o = den_ff;
   assign rem_o = rem_ff;
   assign num_o = num_ff;
   assign quo_o = quo_ff;

endmodule
